// ===== sv/tt2r_pkg.sv =====
// Shared types, opcodes and constants for the type 2 tag command responder.
// No dependencies; used by every module.
`default_nettype none

package tt2r_pkg;

  localparam int unsigned PageCountDefault  = 16;
  localparam int unsigned FrameBytesDefault = 64;
  localparam int unsigned PageBytes         = 4;
  localparam int unsigned ReadBytes         = 16;
  localparam int unsigned MemWords          = 8;
  localparam int unsigned WordBits          = 64;
  localparam int unsigned MemAddrW          = 6;
  localparam int unsigned PageAddrW         = 4;
  localparam int unsigned CfgIdxW           = 3;

  localparam logic [7:0] OpRead     = 8'h30;
  localparam logic [7:0] OpFastRead = 8'h3A;
  localparam logic [7:0] OpVersion  = 8'h60;
  localparam logic [7:0] OpHalt     = 8'h50;
  localparam logic [7:0] NakCode    = 8'h00;

  localparam logic [3:0] BitsData = 4'd8;
  localparam logic [3:0] BitsNak  = 4'd4;
  localparam logic [3:0] BitsNone = 4'd0;

  typedef enum logic [1:0] {
    ACT_TX    = 2'd0,
    ACT_RX    = 2'd1,
    ACT_SLEEP = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_EMIT,
    ST_SINGLE
  } state_e;

  typedef logic [MemWords-1:0][WordBits-1:0] tag_mem_t;

  function automatic logic [7:0] version_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h00;
      3'd1:    b = 8'h04;
      3'd2:    b = 8'h04;
      3'd3:    b = 8'h02;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h00;
      3'd6:    b = 8'h0F;
      3'd7:    b = 8'h03;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== sv/tt2r_if.sv =====
// Valid/ready channel interfaces: command frames in, response transactions out.
// No dependencies; the action field is a plain 2-bit vector.
`default_nettype none

interface tt2r_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] command;
  logic [7:0] first_arg;
  logic [7:0] second_arg;
  logic [6:0] frame_length;

  modport source (output valid, command, first_arg, second_arg, frame_length, input ready);
  modport sink   (input valid, command, first_arg, second_arg, frame_length, output ready);
endinterface

interface tt2r_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] tx_byte;
  logic [3:0] tx_bits;
  logic       append_crc;
  logic       last;

  modport source (output valid, action, tx_byte, tx_bits, append_crc, last, input ready);
  modport sink   (input valid, action, tx_byte, tx_bits, append_crc, last, output ready);
endinterface

`default_nettype wire

// ===== sv/tt2r_page_mod.sv =====
// Bit-serial remainder of an 8-bit page number modulo PAGE_COUNT, one bit per cycle.
// Depends on tt2r_pkg.
`default_nettype none

module tt2r_page_mod #(
  parameter int unsigned PAGE_COUNT = tt2r_pkg::PageCountDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [7:0]                     page_i,
  output logic                                done_o,
  output logic [tt2r_pkg::PageAddrW-1:0]      rem_o
);

  localparam int unsigned PgW = $clog2(PAGE_COUNT);

  logic [7:0]   dvd_q, dvd_d;
  logic [PgW:0] rem_q, rem_d;
  logic [2:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [PgW:0] trial;

  always_comb begin
    trial  = {rem_q[PgW-1:0], dvd_q[7]};
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = page_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[6:0], 1'b0};
      rem_d = (trial >= (PgW+1)'(PAGE_COUNT)) ? trial - (PgW+1)'(PAGE_COUNT) : trial;
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = tt2r_pkg::PageAddrW'(rem_q[PgW-1:0]);

endmodule

`default_nettype wire

// ===== sv/tt2r_byte_shifter.sv =====
// Streams tag memory bytes through a 64-bit word shift register, one byte per advance.
// Depends on tt2r_pkg; the word store lives in the top level.
`default_nettype none

module tt2r_byte_shifter #(
  parameter int unsigned PAGE_COUNT = tt2r_pkg::PageCountDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tt2r_pkg::tag_mem_t            mem_i,
  input  wire logic                          load_i,
  input  wire logic [tt2r_pkg::MemAddrW-1:0] addr_i,
  input  wire logic                          advance_i,
  output logic [7:0]                         byte_o
);

  localparam int unsigned MemBytes = PAGE_COUNT * tt2r_pkg::PageBytes;

  logic [tt2r_pkg::MemAddrW-1:0] addr_q, addr_d, addr_nxt;
  logic [tt2r_pkg::WordBits-1:0] word_q, word_d;

  always_comb begin
    addr_nxt = (addr_q == tt2r_pkg::MemAddrW'(MemBytes - 1)) ? '0 : addr_q + 1'b1;
    addr_d   = addr_q;
    word_d   = word_q;
    if (load_i) begin
      addr_d = addr_i;
      word_d = mem_i[addr_i[5:3]] >> {addr_i[2:0], 3'b000};
    end else if (advance_i) begin
      addr_d = addr_nxt;
      // crossing into the next word (or wrapping to byte zero) reloads
      if (addr_nxt[2:0] == 3'd0) word_d = mem_i[addr_nxt[5:3]];
      else                       word_d = {8'h00, word_q[tt2r_pkg::WordBits-1:8]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else begin
      addr_q <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign byte_o = word_q[7:0];

endmodule

`default_nettype wire

// ===== sv/type2_tag_command_responder_core.sv =====
// Type 2 tag command responder. Accepts one command frame at a time (ready only when idle) and
// answers with one response transaction per transmitted byte, or a single rearm, sleep or NAK
// transaction. Bytes leave one per cycle while the output side keeps up: a read gives 16, a fast
// read 4 per page, the version command 8. A read first waits while the bit-serial remainder
// unit reduces the page number modulo PAGE_COUNT. A waiting response transaction that is held
// off delays the completion of its command and so the next acceptance.
// The tag memory is eight 64-bit configuration words written by index.
// Depends on tt2r_pkg, tt2r_if, tt2r_page_mod and tt2r_byte_shifter.
`default_nettype none

module type2_tag_command_responder_core #(
  parameter int unsigned PAGE_COUNT  = tt2r_pkg::PageCountDefault,
  parameter int unsigned FRAME_BYTES = tt2r_pkg::FrameBytesDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tt2r_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [tt2r_pkg::WordBits-1:0] cfg_wdata_i,
  tt2r_cmd_if.sink                           cmd_i,
  tt2r_rsp_if.source                         rsp_o
);

  localparam int unsigned IdxW     = $clog2(FRAME_BYTES);
  localparam int unsigned MaxPages = FRAME_BYTES / tt2r_pkg::PageBytes;

  tt2r_pkg::tag_mem_t mem_q;
  tt2r_pkg::state_e   state_q, state_d;

  logic [IdxW-1:0] idx_q, idx_d, last_idx_q, last_idx_d;
  logic            src_ver_q, src_ver_d;
  logic [1:0]      single_act_q, single_act_d;
  logic [3:0]      single_bits_q, single_bits_d;

  logic       out_valid_q, out_valid_d;
  logic [1:0] out_act_q, out_act_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic [3:0] out_bits_q, out_bits_d;
  logic       out_crc_q, out_crc_d;
  logic       out_last_q, out_last_d;

  logic                          accept, slot_free;
  logic                          mod_start, mod_done;
  logic [tt2r_pkg::PageAddrW-1:0] mod_rem;
  logic                          sh_load, sh_advance;
  logic [tt2r_pkg::MemAddrW-1:0] sh_addr;
  logic [7:0]                    sh_byte;
  logic [7:0]                    page_diff;
  logic                          fast_ok;
  logic                          is_last;

  assign cmd_i.ready = (state_q == tt2r_pkg::ST_IDLE);
  assign accept    = cmd_i.valid && cmd_i.ready;
  assign slot_free = !out_valid_q || rsp_o.ready;
  assign page_diff = cmd_i.second_arg - cmd_i.first_arg;
  assign fast_ok   = (cmd_i.frame_length >= 7'd3) && (cmd_i.second_arg >= cmd_i.first_arg)
                     && (cmd_i.second_arg < 8'(PAGE_COUNT)) && (page_diff < 8'(MaxPages));
  assign is_last   = (idx_q == last_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_q <= '0;
    end else if (cfg_we_i) begin
      mem_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  tt2r_page_mod #(.PAGE_COUNT(PAGE_COUNT)) u_page_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .page_i  (cmd_i.first_arg),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  tt2r_byte_shifter #(.PAGE_COUNT(PAGE_COUNT)) u_byte_shifter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mem_i     (mem_q),
    .load_i    (sh_load),
    .addr_i    (sh_addr),
    .advance_i (sh_advance),
    .byte_o    (sh_byte)
  );

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    last_idx_d    = last_idx_q;
    src_ver_d     = src_ver_q;
    single_act_d  = single_act_q;
    single_bits_d = single_bits_q;
    mod_start     = 1'b0;
    sh_load       = 1'b0;
    sh_advance    = 1'b0;
    sh_addr       = {mod_rem, 2'b00};
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_act_d     = out_act_q;
    out_byte_d    = out_byte_q;
    out_bits_d    = out_bits_q;
    out_crc_d     = out_crc_q;
    out_last_d    = out_last_q;

    case (state_q)
      tt2r_pkg::ST_IDLE: begin
        if (accept) begin
          idx_d         = '0;
          src_ver_d     = 1'b0;
          single_act_d  = tt2r_pkg::ACT_TX;
          single_bits_d = tt2r_pkg::BitsNak;
          if (cmd_i.frame_length == 7'd0) begin
            single_act_d  = tt2r_pkg::ACT_RX;
            single_bits_d = tt2r_pkg::BitsNone;
            state_d       = tt2r_pkg::ST_SINGLE;
          end else begin
            case (cmd_i.command)
              tt2r_pkg::OpRead: begin
                if (cmd_i.frame_length < 7'd2) begin
                  single_act_d  = tt2r_pkg::ACT_RX;
                  single_bits_d = tt2r_pkg::BitsNone;
                  state_d       = tt2r_pkg::ST_SINGLE;
                end else begin
                  mod_start  = 1'b1;
                  last_idx_d = IdxW'(tt2r_pkg::ReadBytes - 1);
                  state_d    = tt2r_pkg::ST_REDUCE;
                end
              end
              tt2r_pkg::OpFastRead: begin
                if (fast_ok) begin
                  sh_load    = 1'b1;
                  sh_addr    = {cmd_i.first_arg[tt2r_pkg::PageAddrW-1:0], 2'b00};
                  last_idx_d = IdxW'({page_diff, 2'b11});
                  state_d    = tt2r_pkg::ST_EMIT;
                end else begin
                  state_d = tt2r_pkg::ST_SINGLE;
                end
              end
              tt2r_pkg::OpVersion: begin
                src_ver_d  = 1'b1;
                last_idx_d = IdxW'(7);
                state_d    = tt2r_pkg::ST_EMIT;
              end
              tt2r_pkg::OpHalt: begin
                single_act_d  = tt2r_pkg::ACT_SLEEP;
                single_bits_d = tt2r_pkg::BitsNone;
                state_d       = tt2r_pkg::ST_SINGLE;
              end
              default: state_d = tt2r_pkg::ST_SINGLE;
            endcase
          end
        end
      end
      tt2r_pkg::ST_REDUCE: begin
        if (mod_done) begin
          sh_load = 1'b1;
          state_d = tt2r_pkg::ST_EMIT;
        end
      end
      tt2r_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_act_d   = tt2r_pkg::ACT_TX;
          out_byte_d  = src_ver_q ? tt2r_pkg::version_byte(idx_q[2:0]) : sh_byte;
          out_bits_d  = tt2r_pkg::BitsData;
          out_crc_d   = 1'b1;
          out_last_d  = is_last;
          sh_advance  = 1'b1;
          idx_d       = idx_q + 1'b1;
          if (is_last) state_d = tt2r_pkg::ST_IDLE;
        end
      end
      tt2r_pkg::ST_SINGLE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_act_d   = single_act_q;
          out_byte_d  = tt2r_pkg::NakCode;
          out_bits_d  = single_bits_q;
          out_crc_d   = 1'b0;
          out_last_d  = 1'b1;
          state_d     = tt2r_pkg::ST_IDLE;
        end
      end
      default: state_d = tt2r_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tt2r_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_idx_q    <= last_idx_d;
    src_ver_q     <= src_ver_d;
    single_act_q  <= single_act_d;
    single_bits_q <= single_bits_d;
    out_act_q     <= out_act_d;
    out_byte_q    <= out_byte_d;
    out_bits_q    <= out_bits_d;
    out_crc_q     <= out_crc_d;
    out_last_q    <= out_last_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.action     = out_act_q;
  assign rsp_o.tx_byte    = out_byte_q;
  assign rsp_o.tx_bits    = out_bits_q;
  assign rsp_o.append_crc = out_crc_q;
  assign rsp_o.last       = out_last_q;

endmodule

`default_nettype wire
